FILE: hdl/stc_pkg.sv
// Shared types, scan code constants and the key decode table for the scan code text console.
// No dependencies; every other file in hdl/ refers to it by scoped names.
`default_nettype none
package stc_pkg;

  // Set 1 scan codes with a special role.
  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] SC_SPACE        = 8'h39;
  localparam logic [7:0] SC_BACKSPACE    = 8'h0E;
  localparam logic [7:0] SC_ENTER        = 8'h1C;
  localparam logic [7:0] SC_DIGIT_ZERO   = 8'h0B;
  localparam logic [7:0] SC_TOP_FIRST    = 8'h10;
  localparam logic [7:0] SC_HOME_FIRST   = 8'h1E;
  localparam logic [7:0] SC_BOTTOM_FIRST = 8'h2C;
  localparam logic [7:0] SC_BREAK_MASK   = 8'h80;

  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] DIGIT_OFFSET  = 8'h2F;  // code 0x02 maps to '1'
  localparam logic [7:0] CASE_DISTANCE = 8'h20;

  localparam int OUT_WIDTH  = 40;
  localparam int ADDR_BITS  = 11;
  localparam int CELL_BITS  = 16;

  localparam logic [7:0] ROW_TOP [10] = '{8'h71, 8'h77, 8'h65, 8'h72, 8'h74,
                                          8'h79, 8'h75, 8'h69, 8'h6F, 8'h70};
  localparam logic [7:0] ROW_HOME [9] = '{8'h61, 8'h73, 8'h64, 8'h66, 8'h67,
                                          8'h68, 8'h6A, 8'h6B, 8'h6C};
  localparam logic [7:0] ROW_BOTTOM [7] = '{8'h7A, 8'h78, 8'h63, 8'h76, 8'h62,
                                            8'h6E, 8'h6D};

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SHIFT_ON,
    OP_SHIFT_OFF,
    OP_BACKSPACE,
    OP_ENTER,
    OP_PUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       letter;  // character is a lowercase letter that shift may raise
    logic [7:0] ch;
  } cmd_t;

  // Character for a printable make code, zero when the code has none.
  function automatic logic [7:0] decode_char(input logic [7:0] code);
    logic [7:0] ch;
    logic [7:0] idx;
    ch  = 8'h00;
    idx = 8'h00;
    case (code) inside
      SC_SPACE:        ch = CHAR_SPACE;
      [8'h02:8'h0A]:   ch = code + DIGIT_OFFSET;
      SC_DIGIT_ZERO:   ch = CHAR_ZERO;
      [8'h10:8'h19]: begin
        idx = code - SC_TOP_FIRST;
        ch  = ROW_TOP[idx[3:0]];
      end
      [8'h1E:8'h26]: begin
        idx = code - SC_HOME_FIRST;
        ch  = ROW_HOME[idx[3:0]];
      end
      [8'h2C:8'h32]: begin
        idx = code - SC_BOTTOM_FIRST;
        ch  = ROW_BOTTOM[idx[2:0]];
      end
      default:         ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/scancode_text_console.sv
// Scan code text console: one result transfer per accepted scan code transfer.
// Each accepted scan code is stored as a command in the queue at its transfer edge, and the
// result register loads from the queue head when the back end pops it.
// Throughput is one scan code per cycle while m_tready does not hold back the result stream.
// Reset (rst, synchronous, active high) clears the cursor to cell zero, releases shift,
// empties the queue and output register, and sets the text attribute to 15.
`default_nettype none
module scancode_text_console #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: text_attribute, written when cfg_we is high.
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_data,
  // Input stream. s_tdata: scan_code[7:0].
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,
  // Result stream. m_tdata: write_enable[0], write_address[11:1], write_cell[27:12],
  // cursor_after[38:28], zero pad[39].
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata
);

  localparam int TOTAL = COLUMNS * ROWS;

  logic [7:0]    text_attribute;
  logic          q_full;
  logic          q_push;
  stc_pkg::cmd_t front_cmd;
  logic          q_pop;
  logic          q_valid;
  stc_pkg::cmd_t head_cmd;

  // The user must write the attribute register only while the console is idle (the block does not
  // enforce this), so the back end can read it directly as each write cell is built.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= 8'd15;
    end else if (cfg_we) begin
      text_attribute <= cfg_data;
    end
  end

  // The front end classifies the scan code into a command in the cycle of its transfer.
  stc_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (front_cmd)
  );

  // Two commands of slack let input transfers continue while a result waits downstream.
  stc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  // The back end owns the cursor and shift state and the registered result.
  stc_exec #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_exec (
    .clk            (clk),
    .rst            (rst),
    .text_attribute (text_attribute),
    .q_valid        (q_valid),
    .q_cmd          (head_cmd),
    .q_pop          (q_pop),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata)
  );

  // The queue can only fill up behind a result that is waiting in the output register.
  assert property (@(posedge clk) disable iff (rst) !s_tready |-> m_tvalid)
    else $error("input stalled without a pending result");

  // A result without a cell write carries zero address and cell.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[27:1] == 27'd0))
    else $error("non-write result carries address or cell bits");

  // The reported cursor stays inside the buffer.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((TOTAL > 2048) || (32'(m_tdata[38:28]) < TOTAL)))
    else $error("cursor outside the text buffer");

  // A fresh result always follows a queue pop.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !$past(m_tvalid)) |-> $past(q_valid))
    else $error("result appeared without a queued command");

endmodule
`default_nettype wire

FILE: hdl/stc_front.sv
// Front end: accepts scan code transfers and classifies each into a console command.
// Depends on stc_pkg for the command type and the key decode table.
`default_nettype none
module stc_front (
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire logic [7:0]     s_tdata,
  input  wire logic           q_full,
  output logic                q_push,
  output stc_pkg::cmd_t       q_cmd
);

  logic [7:0] ch;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;
  assign ch       = stc_pkg::decode_char(s_tdata);

  always_comb begin
    q_cmd.op     = stc_pkg::OP_NONE;
    q_cmd.ch     = ch;
    q_cmd.letter = (ch >= 8'h61) && (ch <= 8'h7A);
    unique case (s_tdata) inside
      stc_pkg::SC_LSHIFT_MAKE, stc_pkg::SC_RSHIFT_MAKE:   q_cmd.op = stc_pkg::OP_SHIFT_ON;
      stc_pkg::SC_LSHIFT_BREAK, stc_pkg::SC_RSHIFT_BREAK: q_cmd.op = stc_pkg::OP_SHIFT_OFF;
      stc_pkg::SC_BACKSPACE:                              q_cmd.op = stc_pkg::OP_BACKSPACE;
      stc_pkg::SC_ENTER:                                  q_cmd.op = stc_pkg::OP_ENTER;
      default: begin
        // Break codes and unmapped codes decode to no character.
        if (((s_tdata & stc_pkg::SC_BREAK_MASK) == 8'h00) && (ch != 8'h00)) begin
          q_cmd.op = stc_pkg::OP_PUT;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/stc_queue.sv
// Two-entry command queue between the front end and the executing back end.
// Depends on stc_pkg for the command type.
`default_nettype none
module stc_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire stc_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output stc_pkg::cmd_t      head_cmd
);

  stc_pkg::cmd_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

FILE: hdl/stc_exec.sv
// Back end: applies commands to the cursor and shift state and registers each result.
// Depends on stc_pkg for the command type, constants and output layout.
`default_nettype none
module stc_exec #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [7:0]                        text_attribute,
  input  wire logic                              q_valid,
  input  wire stc_pkg::cmd_t                     q_cmd,
  output logic                                   q_pop,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [stc_pkg::OUT_WIDTH-1:0]          m_tdata
);

  localparam int TOTAL = COLUMNS * ROWS;
  localparam int CW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int COLW  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROWW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AW    = stc_pkg::ADDR_BITS;

  logic [CW-1:0]   pos, pos_next;
  logic [COLW-1:0] col, col_next;
  logic [ROWW-1:0] row, row_next;
  logic            shift, shift_next;
  logic            we;
  logic [CW-1:0]   addr;
  logic [7:0]      ch;
  logic            last_col, last_row;
  logic [CW+AW-1:0] addr_ext, pos_ext;
  logic [stc_pkg::CELL_BITS-1:0] wr_cell;

  assign q_pop    = q_valid && (!m_tvalid || m_tready);
  assign last_col = (col == COLW'(COLUMNS - 1));
  assign last_row = (row == ROWW'(ROWS - 1));

  always_comb begin
    pos_next   = pos;
    col_next   = col;
    row_next   = row;
    shift_next = shift;
    we         = 1'b0;
    addr       = '0;
    ch         = 8'h00;
    unique case (q_cmd.op)
      stc_pkg::OP_SHIFT_ON:  shift_next = 1'b1;
      stc_pkg::OP_SHIFT_OFF: shift_next = 1'b0;
      stc_pkg::OP_BACKSPACE: begin
        if (pos != '0) begin
          pos_next = pos - CW'(1);
          if (col == '0) begin
            col_next = COLW'(COLUMNS - 1);
            row_next = row - ROWW'(1);
          end else begin
            col_next = col - COLW'(1);
          end
        end
        we   = 1'b1;
        addr = pos_next;
        ch   = stc_pkg::CHAR_SPACE;
      end
      stc_pkg::OP_ENTER: begin
        col_next = '0;
        if (last_row) begin
          row_next = '0;
          pos_next = '0;
        end else begin
          row_next = row + ROWW'(1);
          pos_next = pos - CW'(col) + CW'(COLUMNS);
        end
      end
      stc_pkg::OP_PUT: begin
        we   = 1'b1;
        addr = pos;
        ch   = (shift && q_cmd.letter) ? (q_cmd.ch - stc_pkg::CASE_DISTANCE) : q_cmd.ch;
        if (last_col) begin
          col_next = '0;
          if (last_row) begin
            row_next = '0;
            pos_next = '0;
          end else begin
            row_next = row + ROWW'(1);
            pos_next = pos + CW'(1);
          end
        end else begin
          col_next = col + COLW'(1);
          pos_next = pos + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign addr_ext = {{AW{1'b0}}, addr};
  assign pos_ext  = {{AW{1'b0}}, pos_next};
  assign wr_cell  = we ? {text_attribute, ch} : 16'h0000;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      col      <= '0;
      row      <= '0;
      shift    <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (q_pop) begin
      pos      <= pos_next;
      col      <= col_next;
      row      <= row_next;
      shift    <= shift_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_tdata <= {1'b0, pos_ext[AW-1:0], wr_cell, addr_ext[AW-1:0], we};
    end
  end

endmodule
`default_nettype wire
